// ===== src/pesc_pkg.sv =====
`default_nettype none

package pesc_pkg;

  // fixed field widths
  localparam int PX_W      = 13;
  localparam int PY_W      = 10;
  localparam int ROW_OUT_W = 6;
  localparam int CX_W      = 10;

  // fixed point layout
  localparam int FRAC_BITS = 16;
  localparam int XSHIFT    = 13;
  localparam int PT_BITS   = 3;

  // rounded row of a y value, (y + 4) >> 3 on 8 bits
  localparam int ROW_W = PY_W + 1 - PT_BITS;

  // edge deltas and slope
  localparam int DX_W      = PX_W + 1;
  localparam int DY_W      = PY_W + 1;
  localparam int QUO_W     = PX_W + FRAC_BITS;
  localparam int INV_W     = QUO_W + 1;
  localparam int OFS_W     = ROW_W + PT_BITS + 1;
  localparam int PROD_W    = OFS_W + INV_W;
  localparam int XW        = 44;
  localparam int CXF_W     = XW - FRAC_BITS;
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_LINE  = 2'd1,
    FUNC_CLOSE = 2'd2
  } func_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic div_step;
    logic fix;
    logic mul;
    logic init;
    logic load_out;
  } pesc_cmd_t;

  typedef struct packed {
    logic draws;
    logic rows_eq;
    logic div_last;
    logic out_last;
  } pesc_sts_t;

endpackage

`default_nettype wire

// ===== src/pesc_if.sv =====
`default_nettype none

interface pesc_in_if import pesc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      func;
  logic [PX_W-1:0] px;
  logic [PY_W-1:0] py;

  modport source(output valid, func, px, py, input ready);
  modport sink(input valid, func, px, py, output ready);
endinterface

interface pesc_out_if import pesc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ROW_OUT_W-1:0] scan_row;
  logic [CX_W-1:0]      cross_x;
  logic                 going_up;
  logic                 last;

  modport source(output valid, scan_row, cross_x, going_up, last, input ready);
  modport sink(input valid, scan_row, cross_x, going_up, last, output ready);
endinterface

`default_nettype wire

// ===== src/pesc_ctrl.sv =====
`default_nettype none

module pesc_ctrl import pesc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pesc_sts_t sts,
  output pesc_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SETUP = 8'b00000010,
    S_DIV   = 8'b00000100,
    S_FIX   = 8'b00001000,
    S_MUL   = 8'b00010000,
    S_INIT  = 8'b00100000,
    S_LOAD  = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.draws) begin
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = sts.rows_eq ? S_IDLE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_out = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (sts.out_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.load_out = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/pesc_datapath.sv =====
`default_nettype none

module pesc_datapath import pesc_pkg::*; #(
  parameter int HEIGHT = 64,
  parameter int WIDTH  = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pesc_cmd_t            cmd,
  output pesc_sts_t            sts,
  input  logic [1:0]           func,
  input  logic [PX_W-1:0]      px,
  input  logic [PY_W-1:0]      py,
  output logic [ROW_OUT_W-1:0] scan_row,
  output logic [CX_W-1:0]      cross_x,
  output logic                 going_up,
  output logic                 last
);

  localparam int XMAX  = WIDTH * 8 - 1;
  localparam int CNT_W = $clog2(HEIGHT + 1);
  localparam logic [PX_W-1:0] X_SAT =
    (XMAX > 2 ** PX_W - 1) ? {PX_W{1'b1}} : PX_W'(XMAX);
  localparam logic [PY_W-1:0] Y_SAT = PY_W'(HEIGHT * 8);
  localparam logic signed [XW-1:0]    X_HALF = XW'(2 ** (FRAC_BITS - 1));
  localparam logic signed [CXF_W-1:0] CX_MAX = CXF_W'(WIDTH - 1);

  // path points
  logic [PX_W-1:0] start_x, prev_x;
  logic [PY_W-1:0] start_y, prev_y;

  // edge being drawn
  logic [PX_W-1:0] ax, bx;
  logic [PY_W-1:0] ay, by;

  // walk and divider registers
  logic                     up;
  logic                     neg_q;
  logic [ROW_W-1:0]         row_cur, row_hi;
  logic signed [OFS_W-1:0]  offset;
  logic [PY_W-1:0]          rem;
  logic [QUO_W-1:0]         quo;
  logic [PY_W-1:0]          dvs;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [CNT_W-1:0]         emit_cnt;
  logic signed [INV_W-1:0]  inv;
  logic signed [PROD_W-1:0] prod;
  logic signed [XW-1:0]     x;

  // combinational
  logic [PX_W-1:0]          px_s;
  logic [PY_W-1:0]          py_s;
  logic [ROW_W-1:0]         ra, rb, row_lo;
  logic signed [DX_W-1:0]   dx;
  logic signed [DY_W-1:0]   dy;
  logic [DX_W-1:0]          dx_abs;
  logic [DY_W-1:0]          dy_abs;
  logic                     up_c;
  logic [PY_W:0]            trial;
  logic                     ge;
  logic signed [XW-1:0]     x_rnd;
  logic signed [CXF_W-1:0]  cx_full, cx_sel;
  logic                     last_c;

  assign px_s = (px > X_SAT) ? X_SAT : px;
  assign py_s = (py > Y_SAT) ? Y_SAT : py;

  assign sts.draws = (func == FUNC_START) || (func == FUNC_LINE) || (func == FUNC_CLOSE);

  // rows of both ends, rounded to nearest
  assign ra = ROW_W'(((PY_W + 1)'(ay) + (PY_W + 1)'(4)) >> PT_BITS);
  assign rb = ROW_W'(((PY_W + 1)'(by) + (PY_W + 1)'(4)) >> PT_BITS);
  assign sts.rows_eq = (ra == rb);

  assign dx     = $signed({1'b0, bx}) - $signed({1'b0, ax});
  assign dy     = $signed({1'b0, by}) - $signed({1'b0, ay});
  assign dx_abs = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
  assign dy_abs = dy[DY_W-1] ? DY_W'(-dy) : DY_W'(dy);
  assign up_c   = !dy[DY_W-1];
  assign row_lo = up_c ? ra : rb;

  // restoring divider, one quotient bit a cycle
  assign trial = {rem, quo[QUO_W-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign sts.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  // crossing x, rounded and clamped
  assign x_rnd   = x + X_HALF;
  assign cx_full = $signed(x_rnd[XW-1:FRAC_BITS]);
  assign cx_sel  = cx_full[CXF_W-1] ? '0 : ((cx_full > CX_MAX) ? CX_MAX : cx_full);
  assign last_c  = ((row_cur + ROW_W'(1)) == row_hi) || (emit_cnt == CNT_W'(HEIGHT - 1));

  assign sts.out_last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
    end else if (cmd.accept) begin
      unique case (func)
        FUNC_START: begin
          start_x <= px_s;
          start_y <= py_s;
          prev_x  <= px_s;
          prev_y  <= py_s;
        end
        FUNC_LINE: begin
          prev_x <= px_s;
          prev_y <= py_s;
        end
        FUNC_CLOSE: begin
          prev_x <= start_x;
          prev_y <= start_y;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ax <= prev_x;
      ay <= prev_y;
      if (func == FUNC_LINE) begin
        bx <= px_s;
        by <= py_s;
      end else begin
        bx <= start_x;
        by <= start_y;
      end
    end

    if (cmd.setup) begin
      up       <= up_c;
      neg_q    <= dx[DX_W-1] ^ dy[DY_W-1];
      row_cur  <= row_lo;
      row_hi   <= up_c ? rb : ra;
      offset   <= $signed({1'b0, row_lo, {PT_BITS{1'b0}}}) - $signed({2'b00, ay});
      rem      <= '0;
      quo      <= {dx_abs[PX_W-1:0], {FRAC_BITS{1'b0}}};
      dvs      <= dy_abs[PY_W-1:0];
      div_cnt  <= '0;
      emit_cnt <= '0;
    end

    if (cmd.div_step) begin
      rem     <= ge ? PY_W'(trial - {1'b0, dvs}) : trial[PY_W-1:0];
      quo     <= {quo[QUO_W-2:0], ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end

    if (cmd.fix) begin
      inv <= neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end

    if (cmd.mul) begin
      prod <= offset * inv;
    end

    if (cmd.init) begin
      x <= $signed({{(XW - PX_W - XSHIFT){1'b0}}, ax, {XSHIFT{1'b0}}})
           + XW'(prod >>> PT_BITS);
    end else if (cmd.load_out) begin
      x <= x + XW'(inv);
    end

    if (cmd.load_out) begin
      scan_row <= row_cur[ROW_OUT_W-1:0];
      cross_x  <= cx_sel[CX_W-1:0];
      going_up <= up;
      last     <= last_c;
      row_cur  <= row_cur + ROW_W'(1);
      emit_cnt <= emit_cnt + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== src/polygon_edge_scanline_crossings.sv =====
`default_nettype none

// channel   | dir | payload                              | role
// ----------+-----+--------------------------------------+-------------------------------
// path_cmd  | in  | func, px, py                         | path commands, points x.3
// crossing  | out | scan_row, cross_x, going_up, last    | one edge crossing per transfer
//
// an edge gives its first crossing once the restoring divider (one quotient bit a cycle)
// and the slope and start x steps are done, then one crossing per cycle while crossing
// is ready; a command that draws no edge (both ends on one row, unknown code) frees the
// block after setup at most; no command is taken until the last crossing of the previous
// one has gone; rst is synchronous and clears the start and last points and the sequencer
// a stalled crossing holds in the output register; the walk waits on it

module polygon_edge_scanline_crossings import pesc_pkg::*; #(
  parameter int HEIGHT = 64,
  parameter int WIDTH  = 1024
) (
  input  logic       clk,
  input  logic       rst,
  pesc_in_if.sink    path_cmd,
  pesc_out_if.source crossing
);

  // command and status between sequencer and datapath
  pesc_cmd_t cmd;
  pesc_sts_t sts;

  // sequencer: accept, setup, divide, slope sign, offset product, start x, walk
  pesc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (path_cmd.valid),
    .in_ready  (path_cmd.ready),
    .out_valid (crossing.valid),
    .out_ready (crossing.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // point store, row rounding, serial divider, x accumulator and output register
  pesc_datapath #(
    .HEIGHT (HEIGHT),
    .WIDTH  (WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .func     (path_cmd.func),
    .px       (path_cmd.px),
    .py       (path_cmd.py),
    .scan_row (crossing.scan_row),
    .cross_x  (crossing.cross_x),
    .going_up (crossing.going_up),
    .last     (crossing.last)
  );

endmodule

`default_nettype wire

// ===== src/pesc_checker.sv =====
`default_nettype none

module pesc_checker import pesc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_going_up,
  input logic       out_last
);

  // a waiting crossing is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("crossing withdrawn before transfer");

  // one command at a time: no command taken while crossings are offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("command taken while crossings pending");

  // an unknown command leaves the block free at once
  a_unknown_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_func != FUNC_START && in_func != FUNC_LINE
      && in_func != FUNC_CLOSE |=> in_ready)
    else $error("unknown command occupied the block");

  // the final crossing ends the run
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("crossing after final marker");

  // a run continues without a gap and keeps its direction
  a_run_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid && $stable(out_going_up))
    else $error("run broken or direction changed");

endmodule

bind polygon_edge_scanline_crossings pesc_checker u_pesc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (path_cmd.valid),
  .in_ready     (path_cmd.ready),
  .in_func      (path_cmd.func),
  .out_valid    (crossing.valid),
  .out_ready    (crossing.ready),
  .out_going_up (crossing.going_up),
  .out_last     (crossing.last)
);

`default_nettype wire
